@@ hdl/swm_pkg.sv @@
// ----------------------------------------------------------------------------
// swm_pkg: shared definitions for the sliding window median filter
// Sample and key widths, default window depth, and the structs that link
// the sorted cells to each other and to the control logic.
// ----------------------------------------------------------------------------
package swm_pkg;

  // sample and configuration widths
  localparam int SAMPLE_W = 32;
  localparam int CFG_W    = 9;

  // sort key: one flag bit above the biased sample, set for an empty cell
  localparam int KEY_W = SAMPLE_W + 1;

  // flipping the sign bit makes unsigned order equal signed order
  localparam logic [SAMPLE_W-1:0] SIGN_BIAS = {1'b1, {(SAMPLE_W-1){1'b0}}};

  // key of an empty slot, above every stored sample
  localparam logic [KEY_W-1:0] KEY_EMPTY = {KEY_W{1'b1}};

  // default window depth
  localparam int WINDOW_MAX_DEF = 256;

  // cells per group in the median select tree
  localparam int GROUP_SIZE = 16;

  // broadcast from control to every cell
  typedef struct packed {
    logic             en;      // an item transfer updates the chain
    logic             remove;  // the oldest sample leaves the chain
    logic [KEY_W-1:0] l_key;   // key of the leaving sample
    logic [KEY_W-1:0] n_key;   // key of the new sample
  } swm_bcast_t;

  // link from one cell to its right neighbor
  typedef struct packed {
    logic [KEY_W-1:0] r_key;   // cell key after the removal step
    logic             le;      // that key is at or below the new sample
  } swm_link_t;

endpackage

@@ hdl/swm_sample_if.sv @@
// ----------------------------------------------------------------------------
// swm_sample_if: sample input channel
// Valid/ready channel that carries one signed sample per transfer.
// ----------------------------------------------------------------------------
interface swm_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [swm_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

@@ hdl/swm_median_if.sv @@
// ----------------------------------------------------------------------------
// swm_median_if: median output channel
// Valid/ready channel that carries one signed median per transfer.
// ----------------------------------------------------------------------------
interface swm_median_if;
  logic                                valid;
  logic                                ready;
  logic signed [swm_pkg::SAMPLE_W-1:0] median;

  modport source (output valid, output median, input ready);
  modport sink   (input valid, input median, output ready);
endinterface

@@ hdl/swm_cfg_if.sv @@
// ----------------------------------------------------------------------------
// swm_cfg_if: configuration write channel
// Valid/ready channel that writes the window size register.
// ----------------------------------------------------------------------------
interface swm_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [swm_pkg::CFG_W-1:0]    window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

@@ hdl/swm_cell.sv @@
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted chain
// Holds one sample. On an update it removes the leaving sample and inserts
// the new one using only its own key and those of its two neighbors.
// ----------------------------------------------------------------------------
module swm_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 9
) (
  input  logic                             clk_i,
  input  swm_pkg::swm_bcast_t              bc_i,
  input  logic [CNT_W-1:0]                 fill_i,
  input  logic [swm_pkg::KEY_W-1:0]        right_key_i,
  input  swm_pkg::swm_link_t               left_i,
  output logic [swm_pkg::KEY_W-1:0]        key_o,
  output swm_pkg::swm_link_t               link_o,
  output logic [swm_pkg::SAMPLE_W-1:0]     value_o
);
  import swm_pkg::*;

  logic [SAMPLE_W-1:0] val_q, val_d;
  logic                occupied;
  logic [KEY_W-1:0]    s_key;
  logic [KEY_W-1:0]    r_key;
  logic [KEY_W-1:0]    new_key;
  logic                keep;
  logic                le;

  // slot holds a sample when its place is below the fill count
  assign occupied = CNT_W'(INDEX) < fill_i;
  assign s_key    = {~occupied, val_q ^ SIGN_BIAS};

  // removal: slots from the leaving sample on take the right neighbor
  assign keep  = ~bc_i.remove | (s_key < bc_i.l_key);
  assign r_key = keep ? s_key : right_key_i;

  // insertion: larger keys move one slot right, new sample drops in the gap
  assign le = r_key <= bc_i.n_key;

  always_comb begin
    if (le) begin
      new_key = r_key;
    end else if (left_i.le) begin
      new_key = bc_i.n_key;
    end else begin
      new_key = left_i.r_key;
    end
    val_d = new_key[SAMPLE_W-1:0] ^ SIGN_BIAS;
  end

  // sample register
  always_ff @(posedge clk_i) begin
    if (bc_i.en) begin
      val_q <= val_d;
    end
  end

  assign key_o   = s_key;
  assign link_o  = '{r_key: r_key, le: le};
  assign value_o = val_q;

endmodule

@@ hdl/swm_median_tree.sv @@
// ----------------------------------------------------------------------------
// swm_median_tree: median slot select
// Two-level and-or tree that picks the middle slot of the chain; the group
// level is registered, the final level feeds the output register.
// ----------------------------------------------------------------------------
module swm_median_tree #(
  parameter int NUM_SLOTS = 256,
  parameter int IDX_W     = 8
) (
  input  logic                         clk_i,
  input  logic                         load_i,
  input  logic [IDX_W-1:0]             mid_i,
  input  logic [swm_pkg::SAMPLE_W-1:0] slot_i [NUM_SLOTS],
  output logic [swm_pkg::SAMPLE_W-1:0] median_o
);
  import swm_pkg::*;

  localparam int NUM_GROUPS = NUM_SLOTS / GROUP_SIZE;

  logic [SAMPLE_W-1:0] grp_d [NUM_GROUPS];
  logic [SAMPLE_W-1:0] grp_q [NUM_GROUPS];

  // first level: one selected slot per group, zero elsewhere
  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      grp_d[g] = '0;
      for (int j = 0; j < GROUP_SIZE; j++) begin
        if (mid_i == IDX_W'(g * GROUP_SIZE + j)) begin
          grp_d[g] = grp_d[g] | slot_i[g * GROUP_SIZE + j];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      grp_q <= grp_d;
    end
  end

  // second level: merge the groups
  always_comb begin
    median_o = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      median_o = median_o | grp_q[g];
    end
  end

endmodule

@@ hdl/sliding_window_median.sv @@
// ----------------------------------------------------------------------------
// sliding_window_median: running median over the most recent samples
// Sorted chain of cells plus an arrival ring; gives the median per sample.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i  - one signed sample per transfer; median_o - one median per
//   transfer once the window is full; cfg_i - writes the window size
//   (0 counts as 1, values above WINDOW_MAX saturate) and flushes the
//   window, so window_size new samples arrive before the next median.
// Throughput: one sample per cycle while the input is not held by a stall. The
//   chain of cells removes the oldest sample and inserts the new one in the
//   cycle of its transfer; the arrival ring has its oldest entry read out ahead of time.
// Path: the median passes from the cell registers through the group stage
//   of the select tree into the output register, and is then valid on
//   median_o.
// Stall: while median_o waits, the select pipeline holds; samples are still
//   taken until one more median is pending in the chain, then the input
//   waits until median_o is taken.
// Reset: window size 1, window empty, no result pending; the ring and the
//   cells need no clearing, since only filled slots are ever read.
// ----------------------------------------------------------------------------
module sliding_window_median #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  swm_cfg_if.sink       cfg_i,
  swm_sample_if.sink    sample_i,
  swm_median_if.source  median_o
);
  import swm_pkg::*;

  localparam int CNT_W     = $clog2(WINDOW_MAX + 1);
  localparam int IDX_W     = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int NUM_SLOTS = ((WINDOW_MAX + GROUP_SIZE - 1) / GROUP_SIZE) * GROUP_SIZE;

  // control registers
  logic [CNT_W-1:0]    k_q, k_d;
  logic [IDX_W-1:0]    mid_q, mid_d;
  logic [CNT_W-1:0]    fill_q, fill_d;
  logic [IDX_W-1:0]    op_q, op_d;
  logic                pend_q, pend_d;
  logic                grp_vld_q, grp_vld_d;
  logic                out_vld_q, out_vld_d;
  logic [SAMPLE_W-1:0] out_q;

  // arrival ring and prefetched oldest entry
  logic [SAMPLE_W-1:0] ring_q [WINDOW_MAX];
  logic [SAMPLE_W-1:0] lv_q;
  logic [IDX_W-1:0]    wr_addr;

  logic                cfg_xfer;
  logic                in_xfer;
  logic                advance;
  logic                full;
  logic                produce;
  logic [CNT_W-1:0]    k_cfg;
  logic [SAMPLE_W-1:0] tree_med;

  swm_bcast_t          bc;
  logic [KEY_W-1:0]    key   [WINDOW_MAX];
  swm_link_t           link  [WINDOW_MAX];
  logic [SAMPLE_W-1:0] slot  [NUM_SLOTS];

  // handshakes
  assign advance        = ~out_vld_q | median_o.ready;
  assign cfg_i.ready    = 1'b1;
  assign sample_i.ready = advance | ~pend_q;
  assign cfg_xfer       = cfg_i.valid & cfg_i.ready;
  assign in_xfer        = sample_i.valid & sample_i.ready;

  // window state
  assign full    = fill_q == k_q;
  assign produce = full | ((fill_q + CNT_W'(1)) == k_q);
  assign wr_addr = full ? op_q : fill_q[IDX_W-1:0];

  // effective window from the written size
  always_comb begin
    if (cfg_i.window_size == '0) begin
      k_cfg = CNT_W'(1);
    end else if (32'(cfg_i.window_size) > WINDOW_MAX) begin
      k_cfg = CNT_W'(WINDOW_MAX);
    end else begin
      k_cfg = CNT_W'(cfg_i.window_size);
    end
  end

  // next control state
  always_comb begin
    k_d       = k_q;
    mid_d     = mid_q;
    fill_d    = fill_q;
    op_d      = op_q;
    pend_d    = pend_q;
    grp_vld_d = grp_vld_q;
    out_vld_d = out_vld_q;
    if (advance) begin
      pend_d    = 1'b0;
      grp_vld_d = pend_q;
      out_vld_d = grp_vld_q;
    end
    if (cfg_xfer) begin
      k_d    = k_cfg;
      mid_d  = IDX_W'((k_cfg - CNT_W'(1)) >> 1);
      fill_d = '0;
      op_d   = '0;
    end else if (in_xfer) begin
      pend_d = pend_d | produce;
      if (full) begin
        op_d = (CNT_W'(op_q) + CNT_W'(1) == k_q) ? '0 : op_q + IDX_W'(1);
      end else begin
        fill_d = fill_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q       <= CNT_W'(1);
      mid_q     <= '0;
      fill_q    <= '0;
      op_q      <= '0;
      pend_q    <= 1'b0;
      grp_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      k_q       <= k_d;
      mid_q     <= mid_d;
      fill_q    <= fill_d;
      op_q      <= op_d;
      pend_q    <= pend_d;
      grp_vld_q <= grp_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // ring write, and read ahead of the next oldest entry with bypass
  always_ff @(posedge clk_i) begin
    if (in_xfer && !cfg_xfer) begin
      ring_q[wr_addr] <= sample_i.sample;
    end
    if (in_xfer && !cfg_xfer && (wr_addr == op_d)) begin
      lv_q <= sample_i.sample;
    end else begin
      lv_q <= ring_q[op_d];
    end
  end

  // broadcast to the chain
  assign bc = '{en:     in_xfer & ~cfg_xfer,
                remove: full,
                l_key:  {1'b0, lv_q ^ SIGN_BIAS},
                n_key:  {1'b0, sample_i.sample ^ SIGN_BIAS}};

  // sorted chain of cells
  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_slot
    if (i < WINDOW_MAX) begin : g_cell
      logic [KEY_W-1:0] right_key;
      swm_link_t        left_link;

      if (i == WINDOW_MAX - 1) begin : g_last
        assign right_key = KEY_EMPTY;
      end else begin : g_mid
        assign right_key = key[i+1];
      end

      if (i == 0) begin : g_first
        assign left_link = '{r_key: '0, le: 1'b1};
      end else begin : g_rest
        assign left_link = link[i-1];
      end

      swm_cell #(
        .INDEX (i),
        .CNT_W (CNT_W)
      ) u_cell (
        .clk_i       (clk_i),
        .bc_i        (bc),
        .fill_i      (fill_q),
        .right_key_i (right_key),
        .left_i      (left_link),
        .key_o       (key[i]),
        .link_o      (link[i]),
        .value_o     (slot[i])
      );
    end else begin : g_pad
      assign slot[i] = '0;
    end
  end

  // median select
  swm_median_tree #(
    .NUM_SLOTS (NUM_SLOTS),
    .IDX_W     (IDX_W)
  ) u_tree (
    .clk_i    (clk_i),
    .load_i   (advance),
    .mid_i    (mid_q),
    .slot_i   (slot),
    .median_o (tree_med)
  );

  // output register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= tree_med;
    end
  end

  assign median_o.valid  = out_vld_q;
  assign median_o.median = out_q;

`ifndef SYNTH
  // fill count never exceeds the window
  a_fill_le_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= k_q) else $error("fill count above window size");

  // oldest pointer stays inside the window
  a_op_lt_k: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(op_q) < k_q) else $error("oldest pointer outside window");

  // chain must not change while a pending median waits to be selected
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_xfer && pend_q && !advance)) else $error("sample taken over pending median");

  // a configuration write empties the window
  a_cfg_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_xfer |=> (fill_q == '0) && (op_q == '0)) else $error("window not flushed");
`endif

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb: testbench for the sliding window median filter
// Streams signed samples through the block under several window sizes,
// predicts each median with a sorted copy of the window and checks every
// median transfer in order, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import swm_pkg::*;

  localparam int WIN_MAX      = WINDOW_MAX_DEF;
  // several times the slowest legal run, long receiver hold-off included
  localparam int LIMIT_CYCLES = 200000;
  localparam int CHOKE_CYCLES = 300;
  localparam int SETTLE       = 10;

  logic clk = 1'b0;
  logic rst_n;

  swm_cfg_if    cfg_if ();
  swm_sample_if smp_if ();
  swm_median_if med_if ();

  sliding_window_median #(
    .WINDOW_MAX (WIN_MAX)
  ) dut (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .cfg_i    (cfg_if),
    .sample_i (smp_if),
    .median_o (med_if)
  );

  // samples waiting to be offered and medians waiting to arrive
  logic signed [SAMPLE_W-1:0] sample_backlog[$];
  logic signed [SAMPLE_W-1:0] pending_medians[$];

  // predicted window: sorted copy, arrival ring, ring head and size register
  logic signed [SAMPLE_W-1:0] win_sorted[$];
  logic signed [SAMPLE_W-1:0] win_ring [WIN_MAX];
  int unsigned                ring_head;
  logic [CFG_W-1:0]           win_reg;

  int src_idle;
  int snk_idle;
  logic choke_req;
  logic sink_hold;

  int unsigned cycles;
  int unsigned fail_count;
  int unsigned samples_sent;
  int unsigned medians_seen;
  int unsigned size_writes;

  always #5 clk = ~clk;

  // window span after the zero and saturation rules
  function automatic int unsigned live_window();
    int unsigned span;
    span = win_reg;
    if (span == 0) span = 1;
    if (span > WIN_MAX) span = WIN_MAX;
    return span;
  endfunction

  // append one sample to the backlog
  task automatic add_sample(input logic signed [SAMPLE_W-1:0] s);
    sample_backlog.insert(sample_backlog.size(), s);
  endtask

  // slide one sample into the predicted window, queue the median if full
  task automatic slide_window(input logic signed [SAMPLE_W-1:0] s);
    int unsigned span;
    int unsigned pos;
    logic signed [SAMPLE_W-1:0] leaving;
    span = live_window();
    if (win_sorted.size() >= span) begin
      if (ring_head >= span) ring_head = 0;
      leaving = win_ring[ring_head];
      // one entry of equal value leaves
      pos = 0;
      while (pos < win_sorted.size() && win_sorted[pos] != leaving) pos++;
      if (pos >= win_sorted.size()) pos = win_sorted.size() - 1;
      win_sorted.delete(pos);
      win_ring[ring_head] = s;
      ring_head = (ring_head + 1) % span;
    end else begin
      win_ring[win_sorted.size()] = s;
    end
    // new sample goes after all equal entries
    pos = 0;
    while (pos < win_sorted.size() && win_sorted[pos] <= s) pos++;
    win_sorted.insert(pos, s);
    if (win_sorted.size() >= span)
      pending_medians.insert(pending_medians.size(), win_sorted[(span - 1) / 2]);
  endtask

  // sample driver: offers backlog items, holds each until its transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      smp_if.valid  <= 1'b0;
      smp_if.sample <= '0;
    end else begin
      if (smp_if.valid && smp_if.ready) begin
        slide_window(smp_if.sample);
        samples_sent++;
      end
      if (!(smp_if.valid && !smp_if.ready)) begin
        if (sample_backlog.size() != 0 && $urandom_range(99) >= src_idle) begin
          smp_if.valid  <= 1'b1;
          smp_if.sample <= sample_backlog.pop_front();
        end else begin
          smp_if.valid <= 1'b0;
        end
      end
    end
  end

  // median monitor: checks each transfer against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      med_if.ready <= 1'b0;
    end else begin
      if (med_if.valid && med_if.ready) begin
        medians_seen++;
        if (pending_medians.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("tb: unexpected median %0d with none pending", med_if.median);
        end else if (med_if.median !== pending_medians[0]) begin
          fail_count++;
          if (fail_count <= 10)
            $display("tb: median mismatch: expected %0d, got %0d",
                     pending_medians[0], med_if.median);
          void'(pending_medians.pop_front());
        end else begin
          void'(pending_medians.pop_front());
        end
      end
      med_if.ready <= !sink_hold && ($urandom_range(99) >= snk_idle);
    end
  end

  // long receiver hold-off so the block fills up and stalls its input
  initial begin
    sink_hold = 1'b0;
    wait (choke_req);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (CHOKE_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("tb: errors");
      $finish;
    end
  end

  // wait until nothing is queued, offered or expected, then let the pipe settle
  task automatic drain();
    @(negedge clk);
    while (sample_backlog.size() != 0 || smp_if.valid || pending_medians.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // size register write; flushes the predicted window on its transfer
  task automatic write_window(input logic [CFG_W-1:0] size);
    @(posedge clk);
    cfg_if.valid       <= 1'b1;
    cfg_if.window_size <= size;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    win_reg   = size;
    ring_head = 0;
    win_sorted.delete();
    size_writes++;
    @(negedge clk);
  endtask

  // mostly wide random values, some extremes, some narrow to force ties
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return {1'b1, {(SAMPLE_W-1){1'b0}}};
          1: return {1'b0, {(SAMPLE_W-1){1'b1}}};
          2: return '0;
          default: return '1;
        endcase
      end
      1, 2, 3: return $signed($urandom_range(8)) - 4;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_random(input int count);
    repeat (count) add_sample(pick_sample());
  endtask

  // stimulus
  initial begin
    int sizes [8];
    int counts [8];
    sizes  = '{0, 2, 5, 16, 256, 7, 511, 0};
    counts = '{60, 150, 150, 220, 300, 150, 300, 100};
    sizes[7] = $urandom_range(1, 40);

    rst_n              = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.window_size = '0;
    smp_if.valid       = 1'b0;
    smp_if.sample      = '0;
    med_if.ready       = 1'b0;
    choke_req          = 1'b0;
    win_reg            = CFG_W'(1);
    ring_head          = 0;
    src_idle           = 20;
    snk_idle           = 50;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset window of one: extremes pass straight through
    add_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
    add_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
    add_sample(0);
    add_sample(-1);
    add_sample(1);
    drain();

    // even window, partial fill then a rewrite that flushes it
    write_window(CFG_W'(4));
    add_sample(100);
    add_sample(-100);
    drain();
    write_window(CFG_W'(4));
    // ties: lower middle of an even window, equal value leaving
    add_sample(7);
    add_sample(7);
    add_sample(-3);
    add_sample(7);
    add_sample(7);
    add_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
    add_sample({1'b1, {(SAMPLE_W-1){1'b0}}});
    add_sample({1'b0, {(SAMPLE_W-1){1'b1}}});
    add_sample(-3);
    add_sample(5);
    add_sample(5);
    add_sample(0);
    drain();

    // random phases over several window sizes, idling pattern per stage
    for (int p = 0; p < 8; p++) begin
      if (p < 3) begin
        src_idle = 20;
        snk_idle = 50;
      end else if (p < 6) begin
        src_idle = 50;
        snk_idle = 20;
      end else begin
        src_idle = 0;
        snk_idle = 0;
      end
      write_window(CFG_W'(sizes[p]));
      if (p == 2) begin
        // sender pauses mid-stream until every median is in
        queue_random(counts[p] / 2);
        drain();
        queue_random(counts[p] - counts[p] / 2);
      end else begin
        queue_random(counts[p]);
        if (p == 3) choke_req = 1'b1;
      end
      drain();
    end

    $display("tb: %0d samples in, %0d medians checked, %0d window size writes",
             samples_sent, medians_seen, size_writes);
    $display("tb: window sizes 0 to 511 covered, long output stall included");
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

@@ sliding_window_median.f @@
hdl/swm_pkg.sv
hdl/swm_sample_if.sv
hdl/swm_median_if.sv
hdl/swm_cfg_if.sv
hdl/swm_cell.sv
hdl/swm_median_tree.sv
hdl/sliding_window_median.sv
bench/tb.sv
